/* hw/rtl/tensor_odf_evaluator_unit_macros.svh */
// assertion macros for the tensor odf evaluator checker
// both sample on clk and are disabled while arst_n is low
`ifndef TENSOR_ODF_EVALUATOR_UNIT_MACROS_SVH
`define TENSOR_ODF_EVALUATOR_UNIT_MACROS_SVH

// consequent checked in the same cycle
`define TOE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define TOE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/toe_pkg.sv */
package toe_pkg;

	localparam int MAX_DIRECTIONS = 64;
	localparam int IDX_W = $clog2(MAX_DIRECTIONS);
	localparam int CNT_W = 7;

	// 4/3*pi in q3.29
	localparam logic [31:0] VOLUME_CONST = 32'd2248839617;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

	// register codes (word address)
	localparam logic [1:0] REG_DIRECTION_COUNT = 2'd0;
	localparam logic [1:0] REG_NORM_MODE = 2'd1;
	localparam logic [1:0] REG_SMALL_THRESHOLD = 2'd2;

	// normalization codes
	localparam logic [1:0] NORM_VOLUME = 2'd1;
	localparam logic [1:0] NORM_SUM = 2'd2;

	typedef enum logic [1:0] {
		DIV_TERM = 2'd0,
		DIV_RECIP = 2'd1,
		DIV_NORM = 2'd2
	} div_sel_t;

	typedef enum logic [1:0] {
		ROOT_ODF = 2'd0,
		ROOT_VOL = 2'd1,
		ROOT_CBRT = 2'd2
	} root_sel_t;

	typedef struct packed {
		logic req_take;
		logic n_clear;
		logic n_inc;
		logic k_clear;
		logic k_inc;
		logic tab_rd;
		logic dot;
		logic sq;
		logic s_clear;
		logic term_add;
		logic div_start;
		div_sel_t div_sel;
		logic root_start;
		root_sel_t root_sel;
		logic val_wr;
		logic s_store;
		logic mul_p1;
		logic mul_p2;
		logic mul_vol;
		logic f_cbrt;
		logic f_sum;
		logic vb_rd;
		logic rsp_load;
	} toe_cmd_t;

	typedef struct packed {
		logic req_mode;
		logic n_last;
		logic k_last;
		logic term_small;
		logic all_small;
		logic sum_small;
		logic div_done;
		logic root_done;
		logic norm_vol;
		logic norm_sum;
		logic norm_zero;
		logic rsp_fire;
	} toe_stat_t;

endpackage

/* hw/rtl/toe_regs.sv */
module toe_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [toe_pkg::CNT_W-1:0] direction_count,
	output logic [1:0]  norm_mode,
	output logic [31:0] small_threshold
);
	import toe_pkg::*;

	logic [CNT_W-1:0] dcount_q;
	logic [1:0]       nmode_q;
	logic [31:0]      thr_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcount_q <= CNT_W'(MAX_DIRECTIONS);
			nmode_q <= 2'd0;
			thr_q <= 32'd512;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_DIRECTION_COUNT: dcount_q <= pwdata[CNT_W-1:0];
				REG_NORM_MODE: nmode_q <= pwdata[1:0];
				REG_SMALL_THRESHOLD: thr_q <= pwdata;
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (paddr[3:2])
			REG_DIRECTION_COUNT: prdata = {{(32-CNT_W){1'b0}}, dcount_q};
			REG_NORM_MODE: prdata = {30'd0, nmode_q};
			REG_SMALL_THRESHOLD: prdata = thr_q;
			default: prdata = 32'd0;
		endcase
	end

	assign direction_count = dcount_q;
	assign norm_mode = nmode_q;
	assign small_threshold = thr_q;

endmodule

/* hw/rtl/toe_div.sv */
module toe_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        done,
	output logic [63:0] quot
);
	import toe_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] den_q;
	logic [64:0] trial;
	logic        fits;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[63]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? 64'(trial - {1'b0, den_q}) : trial[63:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

/* hw/rtl/toe_root.sv */
module toe_root (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  toe_pkg::root_sel_t  sel,
	input  logic [63:0]         x,
	output logic                done,
	output logic [31:0]         res
);
	import toe_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic        cbrt_q;
	logic        ph_q;
	logic [4:0]  b_q;
	logic [63:0] x_q;
	logic [63:0] acc_q;
	logic [63:0] bit_q;
	logic [20:0] r_q;
	logic [41:0] sq_q;
	logic [63:0] try_sum;
	logic [20:0] cand;
	logic [62:0] cube;

	assign try_sum = acc_q + bit_q;
	assign cand = r_q | (21'd1 << b_q);
	assign cube = 63'(sq_q) * 63'(cand);

	// iteration control: 32 steps for the square root, 2 per bit for the cube root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cbrt_q <= 1'b0;
			ph_q <= 1'b0;
			b_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cbrt_q <= (sel == ROOT_CBRT);
				ph_q <= 1'b0;
				b_q <= 5'd20;
			end else if (busy_q) begin
				if (!cbrt_q) begin
					if (bit_q == 64'd1) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end else begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (b_q == 5'd0) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end else begin
							b_q <= b_q - 5'd1;
						end
					end
				end
			end
		end
	end

	// datapath of both roots
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			acc_q <= '0;
			bit_q <= 64'd1 << 62;
			r_q <= '0;
		end else if (busy_q) begin
			if (!cbrt_q) begin
				if (x_q >= try_sum) begin
					x_q <= x_q - try_sum;
					acc_q <= (acc_q >> 1) + bit_q;
				end else begin
					acc_q <= acc_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else if (!ph_q) begin
				sq_q <= 42'(cand) * 42'(cand);
			end else if ({1'b0, cube} <= x_q) begin
				r_q <= cand;
			end
		end
	end

	assign done = done_q;
	assign res = cbrt_q ? {11'd0, r_q} : acc_q[31:0];

endmodule

/* hw/rtl/toe_datapath.sv */
module toe_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  toe_pkg::toe_cmd_t   cmd,
	output toe_pkg::toe_stat_t  stat,
	input  logic [toe_pkg::CNT_W-1:0] direction_count,
	input  logic [1:0]          norm_mode,
	input  logic [31:0]         small_threshold,
	input  logic                mode,
	input  logic [5:0]          table_index,
	input  logic [47:0]         vector_a,
	input  logic [47:0]         vector_b,
	input  logic [47:0]         vector_c,
	input  logic [31:0]         eigval_first,
	input  logic [31:0]         eigval_second,
	input  logic [31:0]         eigval_third,
	input  logic                rsp_stall,
	output logic                rsp_valid,
	output logic [31:0]         odf_value,
	output logic [5:0]          direction_index,
	output logic                last
);
	import toe_pkg::*;

	logic [47:0] dir_mem [MAX_DIRECTIONS];
	logic [31:0] vb_mem [MAX_DIRECTIONS];

	logic [47:0] ea_q, eb_q, ec_q;
	logic [31:0] l1_q, l2_q, l3_q;
	logic [47:0] tab_q;
	logic [31:0] vb_q;
	logic [IDX_W-1:0] n_q;
	logic [1:0]  k_q;
	logic [31:0] m_q;
	logic [63:0] dsq_q;
	logic [63:0] s_q;
	logic [37:0] msum_q;
	logic [31:0] sv1_q, sv2_q, sv3_q;
	logic [31:0] p_q;
	logic [63:0] vol_q;
	logic [37:0] f_q;
	logic        rsp_valid_q;
	logic [31:0] odf_q;
	logic [IDX_W-1:0] idx_q;
	logic        last_q;

	logic [CNT_W-1:0] eff_count;
	logic [47:0] e_sel;
	logic [31:0] l_sel;
	logic signed [33:0] dot_sum;
	logic [33:0] dot_mag;
	logic [63:0] term;
	logic [64:0] s_add;
	logic [31:0] v_val;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [63:0] div_num, div_den, div_q;
	logic        div_done;
	logic [63:0] root_x;
	logic [31:0] root_res;
	logic        root_done;
	logic        norm_vol, norm_sum;
	logic [31:0] rsp_val;

	// effective direction count, clamped to 1..MAX_DIRECTIONS
	always_comb begin
		if (direction_count == '0) eff_count = CNT_W'(1);
		else if (direction_count > CNT_W'(MAX_DIRECTIONS)) eff_count = CNT_W'(MAX_DIRECTIONS);
		else eff_count = direction_count;
	end

	// eigen pair selected by k
	always_comb begin
		case (k_q)
			2'd0: begin e_sel = ea_q; l_sel = l1_q; end
			2'd1: begin e_sel = eb_q; l_sel = l2_q; end
			default: begin e_sel = ec_q; l_sel = l3_q; end
		endcase
	end

	// dot product of direction and eigenvector, magnitude
	assign dot_sum = 34'(signed'(tab_q[15:0]) * signed'(e_sel[15:0]))
		+ 34'(signed'(tab_q[31:16]) * signed'(e_sel[31:16]))
		+ 34'(signed'(tab_q[47:32]) * signed'(e_sel[47:32]));
	assign dot_mag = dot_sum[33] ? 34'(-dot_sum) : 34'(dot_sum);

	// saturating term accumulation
	assign term = stat.term_small ? 64'hFFFF_FFFF_FFFF_FFFF : div_q;
	assign s_add = {1'b0, s_q} + {1'b0, term};

	assign norm_vol = (norm_mode == NORM_VOLUME);
	assign norm_sum = (norm_mode == NORM_SUM);

	// value written back for one direction
	always_comb begin
		if (stat.all_small) v_val = 32'd0;
		else if (stat.sum_small) v_val = SAT32;
		else v_val = root_res;
	end

	// shared multiplier for the volume factor
	always_comb begin
		if (cmd.mul_p1) begin
			mul_a = sv1_q; mul_b = sv2_q;
		end else if (cmd.mul_p2) begin
			mul_a = p_q; mul_b = sv3_q;
		end else begin
			mul_a = p_q; mul_b = VOLUME_CONST;
		end
	end
	assign prod = 64'(mul_a) * 64'(mul_b);

	// divider operand selection
	always_comb begin
		case (cmd.div_sel)
			DIV_TERM: begin
				div_num = dsq_q;
				div_den = {32'd0, l_sel};
			end
			DIV_RECIP: begin
				div_num = 64'd1 << 56;
				div_den = s_q;
			end
			default: begin
				div_num = norm_vol ? {12'd0, vb_q, 20'd0} : {16'd0, vb_q, 16'd0};
				div_den = {26'd0, f_q};
			end
		endcase
	end

	// root operand selection
	always_comb begin
		case (cmd.root_sel)
			ROOT_ODF: root_x = div_q;
			ROOT_VOL: root_x = {l_sel, 32'd0};
			default: root_x = vol_q;
		endcase
	end

	toe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_q)
	);

	toe_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.root_start),
		.sel    (cmd.root_sel),
		.x      (root_x),
		.done   (root_done),
		.res    (root_res)
	);

	// response value, normalized and saturated when normalization is selected
	always_comb begin
		if (!(norm_vol || norm_sum)) rsp_val = vb_q;
		else if (stat.norm_zero) rsp_val = 32'd0;
		else if (div_q[63:32] != 32'd0) rsp_val = SAT32;
		else rsp_val = div_q[31:0];
	end

	// status to the controller
	always_comb begin
		stat.req_mode = mode;
		stat.n_last = (CNT_W'(n_q) + CNT_W'(1)) == eff_count;
		stat.k_last = (k_q == 2'd2);
		stat.term_small = (l_sel <= small_threshold);
		stat.all_small = (l1_q < small_threshold) && (l2_q < small_threshold)
			&& (l3_q < small_threshold);
		stat.sum_small = (s_q == 64'd0)
			|| ((s_q[63:24] == 40'd0) && ({s_q[23:0], 8'd0} < small_threshold));
		stat.div_done = div_done;
		stat.root_done = root_done;
		stat.norm_vol = norm_vol;
		stat.norm_sum = norm_sum;
		stat.norm_zero = norm_vol ? ({f_q[20:0], 12'd0} <= {1'b0, small_threshold})
			: ({f_q, 16'd0} <= {22'd0, small_threshold});
		stat.rsp_fire = rsp_valid_q & ~rsp_stall;
	end

	// direction table and value buffer
	always_ff @(posedge clk) begin
		if (cmd.req_take && !mode) dir_mem[table_index] <= vector_a;
		if (cmd.tab_rd) tab_q <= dir_mem[n_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.val_wr) vb_mem[n_q] <= v_val;
		if (cmd.vb_rd) vb_q <= vb_mem[n_q];
	end

	// control counters and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			k_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.n_clear) n_q <= '0;
			else if (cmd.n_inc) n_q <= n_q + IDX_W'(1);
			if (cmd.k_clear) k_q <= '0;
			else if (cmd.k_inc) k_q <= k_q + 2'd1;
			if (cmd.rsp_load) rsp_valid_q <= 1'b1;
			else if (stat.rsp_fire) rsp_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.req_take) begin
			ea_q <= vector_a;
			eb_q <= vector_b;
			ec_q <= vector_c;
			l1_q <= eigval_first;
			l2_q <= eigval_second;
			l3_q <= eigval_third;
			msum_q <= '0;
		end
		if (cmd.dot) m_q <= dot_mag[31:0];
		if (cmd.sq) dsq_q <= 64'(m_q) * 64'(m_q);
		if (cmd.s_clear) s_q <= '0;
		else if (cmd.term_add) s_q <= s_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s_add[63:0];
		if (cmd.val_wr) msum_q <= msum_q + 38'(v_val);
		if (cmd.s_store) begin
			case (k_q)
				2'd0: sv1_q <= root_res;
				2'd1: sv2_q <= root_res;
				default: sv3_q <= root_res;
			endcase
		end
		if (cmd.mul_p1 || cmd.mul_p2) p_q <= prod[63:32];
		if (cmd.mul_vol) vol_q <= {1'b0, prod[63:29], 28'd0};
		if (cmd.f_cbrt) f_q <= 38'(root_res[20:0]);
		else if (cmd.f_sum) f_q <= msum_q;
		if (cmd.rsp_load) begin
			odf_q <= rsp_val;
			idx_q <= n_q;
			last_q <= stat.n_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign odf_value = odf_q;
	assign direction_index = idx_q;
	assign last = last_q;

endmodule

/* hw/rtl/toe_ctrl.sv */
module toe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  toe_pkg::toe_stat_t stat,
	output toe_pkg::toe_cmd_t  cmd,
	output logic               req_stall
);
	import toe_pkg::*;

	typedef enum logic [20:0] {
		S_IDLE   = 21'd1 << 0,
		S_RD     = 21'd1 << 1,
		S_DOT    = 21'd1 << 2,
		S_SQ     = 21'd1 << 3,
		S_TERM   = 21'd1 << 4,
		S_TDIV   = 21'd1 << 5,
		S_CHK    = 21'd1 << 6,
		S_RDIV   = 21'd1 << 7,
		S_RSQ    = 21'd1 << 8,
		S_VSTART = 21'd1 << 9,
		S_VWAIT  = 21'd1 << 10,
		S_P1     = 21'd1 << 11,
		S_P2     = 21'd1 << 12,
		S_PV     = 21'd1 << 13,
		S_CSTART = 21'd1 << 14,
		S_CWAIT  = 21'd1 << 15,
		S_FSUM   = 21'd1 << 16,
		S_OUTRD  = 21'd1 << 17,
		S_OUTDIV = 21'd1 << 18,
		S_OWAIT  = 21'd1 << 19,
		S_EMIT   = 21'd1 << 20
	} state_t;

	state_t state_q, state_d;
	logic   term_next;
	logic   val_next;

	assign req_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// sequencing of one request
	always_comb begin
		cmd = '0;
		state_d = state_q;
		term_next = 1'b0;
		val_next = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.req_take = 1'b1;
					if (stat.req_mode) begin
						cmd.n_clear = 1'b1;
						state_d = S_RD;
					end
				end
			end
			S_RD: begin
				cmd.tab_rd = 1'b1;
				cmd.k_clear = 1'b1;
				cmd.s_clear = 1'b1;
				state_d = S_DOT;
			end
			S_DOT: begin
				cmd.dot = 1'b1;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.sq = 1'b1;
				state_d = S_TERM;
			end
			S_TERM: begin
				if (stat.term_small) begin
					term_next = 1'b1;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel = DIV_TERM;
					state_d = S_TDIV;
				end
			end
			S_TDIV: begin
				if (stat.div_done) term_next = 1'b1;
			end
			S_CHK: begin
				if (stat.all_small || stat.sum_small) begin
					val_next = 1'b1;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel = DIV_RECIP;
					state_d = S_RDIV;
				end
			end
			S_RDIV: begin
				if (stat.div_done) begin
					cmd.root_start = 1'b1;
					cmd.root_sel = ROOT_ODF;
					state_d = S_RSQ;
				end
			end
			S_RSQ: begin
				if (stat.root_done) val_next = 1'b1;
			end
			S_VSTART: begin
				cmd.root_start = 1'b1;
				cmd.root_sel = ROOT_VOL;
				state_d = S_VWAIT;
			end
			S_VWAIT: begin
				if (stat.root_done) begin
					cmd.s_store = 1'b1;
					if (stat.k_last) begin
						state_d = S_P1;
					end else begin
						cmd.k_inc = 1'b1;
						state_d = S_VSTART;
					end
				end
			end
			S_P1: begin
				cmd.mul_p1 = 1'b1;
				state_d = S_P2;
			end
			S_P2: begin
				cmd.mul_p2 = 1'b1;
				state_d = S_PV;
			end
			S_PV: begin
				cmd.mul_vol = 1'b1;
				state_d = S_CSTART;
			end
			S_CSTART: begin
				cmd.root_start = 1'b1;
				cmd.root_sel = ROOT_CBRT;
				state_d = S_CWAIT;
			end
			S_CWAIT: begin
				if (stat.root_done) begin
					cmd.f_cbrt = 1'b1;
					state_d = S_OUTRD;
				end
			end
			S_FSUM: begin
				cmd.f_sum = 1'b1;
				state_d = S_OUTRD;
			end
			S_OUTRD: begin
				cmd.vb_rd = 1'b1;
				state_d = S_OUTDIV;
			end
			S_OUTDIV: begin
				if ((stat.norm_vol || stat.norm_sum) && !stat.norm_zero) begin
					cmd.div_start = 1'b1;
					cmd.div_sel = DIV_NORM;
					state_d = S_OWAIT;
				end else begin
					cmd.rsp_load = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_OWAIT: begin
				cmd.div_sel = DIV_NORM;
				if (stat.div_done) begin
					cmd.rsp_load = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (stat.rsp_fire) begin
					if (stat.n_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.n_inc = 1'b1;
						state_d = S_OUTRD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase

		// one term added, go to the next eigen pair or to the sum check
		if (term_next) begin
			cmd.term_add = 1'b1;
			if (stat.k_last) begin
				state_d = S_CHK;
			end else begin
				cmd.k_inc = 1'b1;
				state_d = S_DOT;
			end
		end

		// value stored, next direction, or normalization or output after the last one
		if (val_next) begin
			cmd.val_wr = 1'b1;
			if (stat.n_last) begin
				cmd.n_clear = 1'b1;
				cmd.k_clear = 1'b1;
				if (stat.norm_vol) state_d = S_VSTART;
				else if (stat.norm_sum) state_d = S_FSUM;
				else state_d = S_OUTRD;
			end else begin
				cmd.n_inc = 1'b1;
				state_d = S_RD;
			end
		end
	end

endmodule

/* hw/rtl/tensor_odf_evaluator_unit.sv */
// tensor odf evaluator
// request channel (req_valid/req_stall): mode 0 stores vector_a as direction
// table_index and the block takes the next request right away.
// mode 1 takes one voxel's eigenvectors and eigenvalues and answers with one
// response per configured direction (odf_value, direction_index, last) on the
// rsp_valid/rsp_stall channel, last marking the final direction.
// each direction uses the shared divider (one quotient bit per cycle) up to
// three times for the terms and once for the reciprocal, plus the square root
// unit. with volume normalization the unit volume factor is worked out after
// the last direction, and each normalized response takes one more divide. all
// directions of a voxel are worked out before its first response; one voxel is
// worked on at a time, and req_stall stays high until its last response is taken.
// configuration goes through the apb port (direction_count, norm_mode,
// small_threshold at byte 0, 4, 8); the user must do it while the block is idle;
// the block does not enforce this. reset clears the control state and restores
// the register defaults; the direction table is undefined until written.
// a stalled response holds its value until rsp_stall drops.
module tensor_odf_evaluator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        mode,
	input  logic [5:0]  table_index,
	input  logic [47:0] vector_a,
	input  logic [47:0] vector_b,
	input  logic [47:0] vector_c,
	input  logic [31:0] eigval_first,
	input  logic [31:0] eigval_second,
	input  logic [31:0] eigval_third,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [31:0] odf_value,
	output logic [5:0]  direction_index,
	output logic        last
);
	import toe_pkg::*;

	logic [CNT_W-1:0] direction_count;
	logic [1:0]       norm_mode;
	logic [31:0]      small_threshold;
	toe_cmd_t         cmd;
	toe_stat_t        stat;

	toe_regs u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.direction_count (direction_count),
		.norm_mode       (norm_mode),
		.small_threshold (small_threshold)
	);

	toe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.stat      (stat),
		.cmd       (cmd),
		.req_stall (req_stall)
	);

	toe_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.direction_count (direction_count),
		.norm_mode       (norm_mode),
		.small_threshold (small_threshold),
		.mode            (mode),
		.table_index     (table_index),
		.vector_a        (vector_a),
		.vector_b        (vector_b),
		.vector_c        (vector_c),
		.eigval_first    (eigval_first),
		.eigval_second   (eigval_second),
		.eigval_third    (eigval_third),
		.rsp_stall       (rsp_stall),
		.rsp_valid       (rsp_valid),
		.odf_value       (odf_value),
		.direction_index (direction_index),
		.last            (last)
	);

endmodule

/* hw/rtl/toe_checker.sv */
`include "tensor_odf_evaluator_unit_macros.svh"

module toe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        mode,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [31:0] odf_value,
	input logic [5:0]  direction_index,
	input logic        last
);

	// a stalled response holds
	`TOE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(odf_value) && $stable(direction_index) && $stable(last), "stalled response changed")

	// no request is taken while a response is pending
	`TOE_ASSERT_SAME(a_busy_stall, rsp_valid, req_stall, "request taken with response pending")

	// the highest table entry always closes the voxel
	`TOE_ASSERT_SAME(a_last_top, rsp_valid && (direction_index == 6'd63), last, "entry 63 not last")

	// responses come one at a time
	`TOE_ASSERT_NEXT(a_rsp_gap, rsp_valid && !rsp_stall, !rsp_valid, "back to back responses")

	// an evaluate request blocks further requests
	`TOE_ASSERT_NEXT(a_eval_stall, req_valid && !req_stall && mode, req_stall, "evaluate request not stalling")

endmodule

bind tensor_odf_evaluator_unit toe_checker u_toe_checker (.*);

/* tb/tensor_odf_evaluator_unit_test.sv */
module tensor_odf_evaluator_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import toe_pkg::*;

	localparam int IDLE_LIMIT = 200000;

	typedef struct packed {
		logic [31:0] odf_value;
		logic [5:0]  direction_index;
		logic        last;
	} odf_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic        mode = 1'b0;
	logic [5:0]  table_index = '0;
	logic [47:0] vector_a = '0;
	logic [47:0] vector_b = '0;
	logic [47:0] vector_c = '0;
	logic [31:0] eigval_first = '0;
	logic [31:0] eigval_second = '0;
	logic [31:0] eigval_third = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [31:0] odf_value;
	logic [5:0]  direction_index;
	logic        last;

	// shadow of the block state
	logic [47:0] dir_table [MAX_DIRECTIONS];
	logic [31:0] odf_buf [MAX_DIRECTIONS];
	logic [6:0]  cfg_count = 7'd64;
	logic [1:0]  cfg_norm = 2'd0;
	logic [31:0] cfg_thresh = 32'd512;

	odf_result_t expected_odf [$];
	int          err_cnt = 0;
	int          idle_cycles = 0;
	bit          calm = 1'b0;
	int          hold_gen = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          stall_left = 0;

	tensor_odf_evaluator_unit u_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		err_cnt++;
	endtask

	function automatic logic [63:0] sqrt_floor(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] cbrt_floor(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] c;
		r = 0;
		for (int b = 20; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (c * c * c <= x) r = c;
		end
		return r;
	endfunction

	function automatic logic [63:0] dot_square(input logic [47:0] d, input logic [47:0] e);
		longint s;
		logic [63:0] m;
		s = 0;
		for (int k = 0; k < 3; k++)
			s += longint'($signed(d[16*k +: 16])) * longint'($signed(e[16*k +: 16]));
		m = (s < 0) ? -s : s;
		return m * m;
	endfunction

	function automatic logic [63:0] lambda_term(input logic [63:0] dsq, input logic [31:0] lam);
		if (lam > cfg_thresh) return dsq / lam;
		return '1;
	endfunction

	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = a + b;
		return s[64] ? '1 : s[63:0];
	endfunction

	// expected responses of one voxel
	task automatic predict_voxel(input logic [47:0] ea, input logic [47:0] eb,
			input logic [47:0] ec, input logic [31:0] l1, input logic [31:0] l2,
			input logic [31:0] l3);
		int cnt;
		bit all_small;
		logic [63:0] s, v, f, p;
		int shift;
		odf_result_t r;
		cnt = (cfg_count == 0) ? 1 : (cfg_count > MAX_DIRECTIONS ? MAX_DIRECTIONS : cfg_count);
		all_small = l1 < cfg_thresh && l2 < cfg_thresh && l3 < cfg_thresh;
		for (int n = 0; n < cnt; n++) begin
			s = lambda_term(dot_square(dir_table[n], ea), l1);
			s = add_sat(s, lambda_term(dot_square(dir_table[n], eb), l2));
			s = add_sat(s, lambda_term(dot_square(dir_table[n], ec), l3));
			if (all_small) v = 0;
			else if (s == 0 || (s < (64'd1 << 24) && (s << 8) < cfg_thresh)) v = SAT32;
			else v = sqrt_floor((64'd1 << 56) / s);
			if (v > SAT32) v = SAT32;
			odf_buf[n] = v[31:0];
		end
		if (cfg_norm == NORM_VOLUME || cfg_norm == NORM_SUM) begin
			if (cfg_norm == NORM_VOLUME) begin
				p = (sqrt_floor({l1, 32'd0}) * sqrt_floor({l2, 32'd0})) >> 32;
				p = (p * sqrt_floor({l3, 32'd0})) >> 32;
				f = cbrt_floor(((p * VOLUME_CONST) >> 29) << 28);
				shift = 20;
				if ((f << 12) <= cfg_thresh) f = 0;
			end else begin
				f = 0;
				for (int n = 0; n < cnt; n++) f += odf_buf[n];
				shift = 16;
				if ((f << 16) <= cfg_thresh) f = 0;
			end
			for (int n = 0; n < cnt; n++) begin
				v = 0;
				if (f != 0) begin
					v = ({32'd0, odf_buf[n]} << shift) / f;
					if (v > SAT32) v = SAT32;
				end
				odf_buf[n] = v[31:0];
			end
		end
		for (int n = 0; n < cnt; n++) begin
			r.odf_value = odf_buf[n];
			r.direction_index = n[5:0];
			r.last = (n + 1 == cnt);
			expected_odf.push_back(r);
		end
	endtask

	// one request, accepted when valid is high and stall low
	task automatic send_request(input logic m, input logic [5:0] idx, input logic [47:0] va,
			input logic [47:0] vb, input logic [47:0] vc, input logic [31:0] l1,
			input logic [31:0] l2, input logic [31:0] l3);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mode <= m;
		table_index <= idx;
		vector_a <= va;
		vector_b <= vb;
		vector_c <= vc;
		eigval_first <= l1;
		eigval_second <= l2;
		eigval_third <= l3;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		if (m == 1'b0) dir_table[idx] = va;
		else predict_voxel(va, vb, vc, l1, l2, l3);
	endtask

	task automatic load_direction(input logic [5:0] idx, input logic [47:0] d);
		send_request(1'b0, idx, d, 48'($urandom), 48'($urandom), $urandom, $urandom,
			$urandom);
	endtask

	task automatic eval_voxel(input logic [47:0] va, input logic [47:0] vb,
			input logic [47:0] vc, input logic [31:0] l1, input logic [31:0] l2,
			input logic [31:0] l3);
		send_request(1'b1, 6'($urandom), va, vb, vc, l1, l2, l3);
	endtask

	// register write: setup cycle then access cycle
	task automatic cfg_write(input logic [1:0] reg_code, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_code, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (reg_code)
			REG_DIRECTION_COUNT: cfg_count = value[6:0];
			REG_NORM_MODE: cfg_norm = value[1:0];
			default: cfg_thresh = value;
		endcase
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (expected_odf.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_config(input logic [6:0] cnt, input logic [1:0] nm,
			input logic [31:0] thr);
		wait_idle();
		cfg_write(REG_DIRECTION_COUNT, 32'(cnt));
		cfg_write(REG_NORM_MODE, 32'(nm));
		cfg_write(REG_SMALL_THRESHOLD, thr);
	endtask

	function automatic logic [47:0] rand_vector();
		logic [15:0] c [3];
		if ($urandom_range(0, 7) == 0) return 48'({$urandom, $urandom});
		for (int k = 0; k < 3; k++) c[k] = 16'($signed($urandom_range(0, 32768)) - 16384);
		return {c[2], c[1], c[0]};
	endfunction

	function automatic logic [31:0] rand_eigval();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 4096);
			2: return $urandom >> $urandom_range(0, 31);
			default: return $urandom_range(32'h0010_0000, 32'h8000_0000);
		endcase
	endfunction

	task automatic rand_voxel();
		eval_voxel(rand_vector(), rand_vector(), rand_vector(),
			rand_eigval(), rand_eigval(), rand_eigval());
	endtask

	// every table entry written up front, so no read hits an empty entry
	task automatic test_table_fill();
		calm = 1'b1;
		load_direction(6'd0, 48'h0000_0000_4000);
		load_direction(6'd1, 48'h0000_4000_0000);
		load_direction(6'd2, 48'h4000_0000_0000);
		for (int i = 3; i < MAX_DIRECTIONS; i++) load_direction(i[5:0], rand_vector());
		calm = 1'b0;
	endtask

	task automatic test_directed();
		// reset config: all 64 directions
		eval_voxel(48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000,
			32'h4000_0000, 32'h1000_0000, 32'h0400_0000);
		// count 0 acts as one, count 127 as the maximum
		set_config(7'd0, 2'd0, 32'd512);
		load_direction(6'd0, 48'h7FFF_7FFF_7FFF);
		eval_voxel(48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h0, '1, '1, '1);
		load_direction(6'd0, 48'h0);
		// zero direction: sum is zero, value saturates
		eval_voxel(48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000,
			32'h4000_0000, 32'h4000_0000, 32'h4000_0000);
		load_direction(6'd0, 48'h0000_0000_4000);
		set_config(7'd4, 2'd0, 32'd0);
		// zero eigenvalues with zero threshold: terms saturate
		eval_voxel(48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000, 0, 0, 0);
		eval_voxel(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000, 1, 1, 1);
		set_config(7'd4, 2'd0, 32'd5000);
		// all eigenvalues small, one small, tiny sum
		eval_voxel(rand_vector(), rand_vector(), rand_vector(), 4999, 0, 100);
		eval_voxel(48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000,
			5000, '1, '1);
		eval_voxel(48'h0000_0000_0001, 48'h0000_0001_0000, 48'h0001_0000_0000,
			'1, '1, '1);
		set_config(7'd127, NORM_VOLUME, 32'd512);
		eval_voxel(48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000,
			32'h2000_0000, 32'h0800_0000, 32'h0100_0000);
		set_config(7'd5, NORM_VOLUME, '1);
		eval_voxel(rand_vector(), rand_vector(), rand_vector(), '1, '1, '1);
		set_config(7'd5, NORM_VOLUME, 32'd512);
		eval_voxel(rand_vector(), rand_vector(), rand_vector(), 10, 20, 30);
		eval_voxel(rand_vector(), rand_vector(), rand_vector(), '1, '1, '1);
		set_config(7'd5, NORM_SUM, 32'd512);
		eval_voxel(rand_vector(), rand_vector(), rand_vector(),
			32'h4000_0000, 32'h1000_0000, 32'h0400_0000);
		eval_voxel(rand_vector(), rand_vector(), rand_vector(), 600, 700, 800);
		set_config(7'd5, NORM_SUM, '1);
		eval_voxel(rand_vector(), rand_vector(), rand_vector(), '1, 32'h8000_0000, 1);
		// unused norm code acts as none
		set_config(7'd3, 2'd3, 32'd512);
		eval_voxel(rand_vector(), rand_vector(), rand_vector(),
			32'h4000_0000, 32'h1000_0000, 32'h0400_0000);
	endtask

	task automatic test_random();
		logic [31:0] thr;
		for (int ph = 0; ph < 10; ph++) begin
			case ($urandom_range(0, 3))
				0: thr = 32'd512;
				1: thr = $urandom_range(0, 4096);
				2: thr = $urandom >> $urandom_range(8, 31);
				default: thr = (ph == 9) ? '1 : $urandom;
			endcase
			set_config(7'($urandom_range(1, 5)), 2'($urandom_range(0, 3)), thr);
			calm = (ph % 4 == 3);
			for (int i = 0; i < 16; i++) begin
				if ($urandom_range(0, 9) < 3) load_direction(6'($urandom), rand_vector());
				else rand_voxel();
			end
		end
		calm = 1'b0;
	endtask

	// receiver holds off while requests keep coming
	task automatic test_backpressure();
		set_config(7'd8, NORM_SUM, 32'd512);
		hold_gen++;
		for (int i = 0; i < 6; i++) begin
			rand_voxel();
			load_direction(6'($urandom), rand_vector());
		end
		set_config(7'd64, NORM_VOLUME, 32'd512);
		rand_voxel();
	endtask

	// response stall, drawn per response, plus a long hold on request
	always @(posedge clk) begin
		if (hold_gen != hold_seen) begin
			hold_seen <= hold_gen;
			hold_left <= 4000;
			rsp_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else if (rsp_valid && !rsp_stall) begin
			stall_left = calm ? 0 : $urandom_range(0, 10);
			rsp_stall <= (stall_left > 0);
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			rsp_stall <= (stall_left > 0);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// response check against the oldest expectation
	always @(posedge clk) begin
		odf_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_odf.size() == 0) begin
				report_mismatch("unexpected response", 64'(odf_value), 64'd0);
			end else begin
				want = expected_odf.pop_front();
				if (odf_value !== want.odf_value)
					report_mismatch("odf_value", 64'(odf_value), 64'(want.odf_value));
				if (direction_index !== want.direction_index)
					report_mismatch("direction_index", 64'(direction_index),
						64'(want.direction_index));
				if (last !== want.last)
					report_mismatch("last", 64'(last), 64'(want.last));
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_fill();
		test_directed();
		test_random();
		test_backpressure();
		wait_idle();
		repeat (100) @(posedge clk);
		if (err_cnt == 0 && expected_odf.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/toe_pkg.sv
hw/rtl/toe_regs.sv
hw/rtl/toe_div.sv
hw/rtl/toe_root.sv
hw/rtl/toe_datapath.sv
hw/rtl/toe_ctrl.sv
hw/rtl/tensor_odf_evaluator_unit.sv
hw/rtl/toe_checker.sv
tb/tensor_odf_evaluator_unit_test.sv
